### src/assert_macros.svh
// Assertion macros used by the selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define SBS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that cond never holds at a clock edge outside reset.
`define SBS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### src/sbs_pkg.sv
// Package for the straightest branch selector: codes, types and the angle table.
`timescale 1ns / 1ps
package sbs_pkg;

	localparam int SBS_MAX_CANDIDATES = 16;
	localparam int SBS_CORDIC_STEPS   = 16;

	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_CAND  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [1:0] CFG_ALLOW_UTURN = 2'd0;
	localparam logic [1:0] CFG_UTURN_THR   = 2'd1;

	localparam logic [15:0] THR_RESET = 16'd27307;

	typedef enum logic {
		ST_IDLE,
		ST_WAIT
	} sel_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_ABS,
		U_NORM,
		U_ROT,
		U_ROUND
	} unit_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// atan(2^-i) in 1/256 binary angle units, pi = 32768 units.
	function automatic logic [21:0] atan_entry(input logic [4:0] idx);
		logic [21:0] val;
		case (idx)
			5'd0:  val = 22'd2097152;
			5'd1:  val = 22'd1238021;
			5'd2:  val = 22'd654136;
			5'd3:  val = 22'd332050;
			5'd4:  val = 22'd166669;
			5'd5:  val = 22'd83416;
			5'd6:  val = 22'd41718;
			5'd7:  val = 22'd20860;
			5'd8:  val = 22'd10430;
			5'd9:  val = 22'd5215;
			5'd10: val = 22'd2608;
			5'd11: val = 22'd1304;
			5'd12: val = 22'd652;
			5'd13: val = 22'd326;
			5'd14: val = 22'd163;
			5'd15: val = 22'd81;
			5'd16: val = 22'd41;
			5'd17: val = 22'd20;
			5'd18: val = 22'd10;
			5'd19: val = 22'd5;
			5'd20: val = 22'd3;
			5'd21: val = 22'd1;
			5'd22: val = 22'd1;
			default: val = 22'd0;
		endcase
		return val;
	endfunction

endpackage

### src/sbs_turn_unit.sv
// Iterative turn-angle unit: shared multiplier, normalizer and CORDIC vectoring loop.
`timescale 1ns / 1ps
module sbs_turn_unit #(
	parameter int CORDIC_STEPS = sbs_pkg::SBS_CORDIC_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  in_x,
	input  logic signed [15:0]  in_z,
	input  logic signed [15:0]  cand_x,
	input  logic signed [15:0]  cand_z,
	output sbs_pkg::unit_stat_t stat,
	output logic [15:0]         mag
);
	import sbs_pkg::*;

	localparam int StepW = $clog2(CORDIC_STEPS);

	unit_state_t state_q, state_d;
	logic done_q;

	logic signed [15:0] ix_q, iz_q, ox_q, oz_q;
	logic [2:0]         mcnt_q;
	logic signed [31:0] prod_q;
	logic signed [32:0] cross_q, dot_q;
	logic               left_q;
	logic signed [34:0] cx_q, cy_q;
	logic signed [24:0] z_q;
	logic [StepW-1:0]   step_q;
	logic [15:0]        mag_q;

	logic signed [15:0] mul_a, mul_b;
	logic [31:0]        norm_or;
	logic               norm_done, norm_by4, last_step;
	logic signed [34:0] sx, sy;
	logic signed [24:0] ang_step, z_round, q_full;
	logic [14:0]        q_clamp;

	// multiplier operand order: ix*oz, iz*ox, ix*ox, iz*oz
	always_comb begin
		case (mcnt_q[1:0])
			2'd0: begin
				mul_a = ix_q;
				mul_b = oz_q;
			end
			2'd1: begin
				mul_a = iz_q;
				mul_b = ox_q;
			end
			2'd2: begin
				mul_a = ix_q;
				mul_b = ox_q;
			end
			default: begin
				mul_a = iz_q;
				mul_b = oz_q;
			end
		endcase
	end

	assign norm_or   = cx_q[31:0] | cy_q[31:0];
	assign norm_done = (norm_or == 32'd0) || (norm_or[31:30] != 2'b00);
	assign norm_by4  = (norm_or[31:26] == 6'd0);
	assign last_step = (step_q == StepW'(CORDIC_STEPS - 1));
	assign sx        = cx_q >>> step_q;
	assign sy        = cy_q >>> step_q;
	assign ang_step  = signed'(25'(atan_entry(5'(step_q))));
	assign z_round   = z_q + 25'sd128;
	assign q_full    = z_round >>> 8;

	always_comb begin
		if (q_full < 25'sd0) begin
			q_clamp = 15'd0;
		end else if (q_full > 25'sd16384) begin
			q_clamp = 15'd16384;
		end else begin
			q_clamp = q_full[14:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE:  if (start) state_d = U_MUL;
			U_MUL:   if (mcnt_q == 3'd4) state_d = U_ABS;
			U_ABS:   state_d = U_NORM;
			U_NORM:  if (norm_done) state_d = U_ROT;
			U_ROT:   if (last_step) state_d = U_ROUND;
			U_ROUND: state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != U_IDLE);
		stat.done = done_q;
	end

	assign mag = mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == U_ROUND);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (start) begin
					ix_q   <= in_x;
					iz_q   <= in_z;
					ox_q   <= cand_x;
					oz_q   <= cand_z;
					mcnt_q <= 3'd0;
				end
			end
			U_MUL: begin
				prod_q <= mul_a * mul_b;
				mcnt_q <= mcnt_q + 3'd1;
				// accumulate the product registered in the previous cycle
				case (mcnt_q)
					3'd1: cross_q <= 33'(prod_q);
					3'd2: cross_q <= cross_q - 33'(prod_q);
					3'd3: dot_q   <= 33'(prod_q);
					3'd4: dot_q   <= dot_q + 33'(prod_q);
					default: ;
				endcase
			end
			U_ABS: begin
				left_q <= (dot_q < 33'sd0);
				cx_q   <= 35'((dot_q < 33'sd0) ? -dot_q : dot_q);
				cy_q   <= 35'((cross_q < 33'sd0) ? -cross_q : cross_q);
				z_q    <= 25'sd0;
				step_q <= '0;
			end
			U_NORM: begin
				// bring the larger operand into [2^30, 2^31]
				if (!norm_done) begin
					if (norm_by4) begin
						cx_q <= cx_q <<< 4;
						cy_q <= cy_q <<< 4;
					end else begin
						cx_q <= cx_q <<< 1;
						cy_q <= cy_q <<< 1;
					end
				end
			end
			U_ROT: begin
				if (cy_q > 35'sd0) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					z_q  <= z_q + ang_step;
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					z_q  <= z_q - ang_step;
				end
				step_q <= step_q + StepW'(1);
			end
			U_ROUND: begin
				mag_q <= left_q ? (16'd32768 - {1'b0, q_clamp}) : {1'b0, q_clamp};
			end
			default: ;
		endcase
	end

endmodule

### src/straightest_branch_selector.sv
// Each candidate goes through the shared turn unit: four multiplier passes, normalize shifts
// and one CORDIC step a cycle. Begin and end items do not occupy the turn unit; no input
// is taken while a candidate is evaluated. Outside that evaluation, an end item is held off
// only while an earlier result still waits on the output register.
// Reset (arst_n low, asynchronous) clears the query state, the output valid and the registers
// (allow_uturn = 0, uturn_threshold = 27307).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module straightest_branch_selector #(
	parameter int MAX_CANDIDATES = sbs_pkg::SBS_MAX_CANDIDATES,
	parameter int CORDIC_STEPS   = sbs_pkg::SBS_CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [15:0] heading_x,
	input  logic signed [15:0] heading_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [3:0]         best_index,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import sbs_pkg::*;

	localparam int CntW = $clog2(MAX_CANDIDATES + 1);
	localparam int PosW = $clog2(MAX_CANDIDATES);

	sel_state_t state_q, state_d;

	logic               allow_q;
	logic [15:0]        thr_q;
	logic signed [15:0] inc_x_q, inc_z_q;
	logic [CntW-1:0]    count_q;
	logic [PosW-1:0]    pos_q, best_pos_q;
	logic [15:0]        best_mag_q;
	logic               have_best_q, overflowed_q;

	logic               out_valid_q, found_q, overflow_q;
	logic [3:0]         best_index_q;

	logic               accept, full, inc_zero, cand_zero, unit_start;
	logic               qualify, better;
	logic [PosW+3:0]    best_pos_ext;
	unit_stat_t         ustat;
	logic [15:0]        umag;

	sbs_turn_unit #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_turn (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.in_x   (inc_x_q),
		.in_z   (inc_z_q),
		.cand_x (heading_x),
		.cand_z (heading_z),
		.stat   (ustat),
		.mag    (umag)
	);

	assign accept    = in_valid && in_ready;
	assign full      = (count_q >= CntW'(MAX_CANDIDATES));
	assign inc_zero  = (inc_x_q == 16'sd0) && (inc_z_q == 16'sd0);
	assign cand_zero = (heading_x == 16'sd0) && (heading_z == 16'sd0);
	assign qualify   = allow_q || (umag < thr_q);
	assign better    = qualify && (umag < best_mag_q);
	assign best_pos_ext = {4'd0, best_pos_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (unit_start) state_d = ST_WAIT;
			ST_WAIT: if (ustat.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		unit_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// hold an end item while the previous answer is still pending
				in_ready   = (op != OP_END) || !out_valid_q || out_ready;
				unit_start = in_valid && (op == OP_CAND) && !full && !inc_zero && !cand_zero;
			end
			ST_WAIT: ;
			default: ;
		endcase
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign best_index = best_index_q;
	assign overflow   = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			allow_q      <= 1'b0;
			thr_q        <= THR_RESET;
			inc_x_q      <= 16'sd0;
			inc_z_q      <= 16'sd0;
			count_q      <= '0;
			pos_q        <= '0;
			best_pos_q   <= '0;
			best_mag_q   <= 16'hFFFF;
			have_best_q  <= 1'b0;
			overflowed_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ALLOW_UTURN: allow_q <= cfg_data[0];
					CFG_UTURN_THR:   thr_q   <= cfg_data;
					default: ;
				endcase
			end

			if (accept && op == OP_END) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == ST_WAIT && ustat.done && better) begin
				best_mag_q  <= umag;
				best_pos_q  <= pos_q;
				have_best_q <= 1'b1;
			end

			if (accept) begin
				unique case (op)
					OP_BEGIN: begin
						inc_x_q      <= heading_x;
						inc_z_q      <= heading_z;
						count_q      <= '0;
						best_pos_q   <= '0;
						best_mag_q   <= 16'hFFFF;
						have_best_q  <= 1'b0;
						overflowed_q <= 1'b0;
					end
					OP_CAND: begin
						if (full) begin
							overflowed_q <= 1'b1;
						end else begin
							pos_q   <= count_q[PosW-1:0];
							count_q <= count_q + CntW'(1);
						end
					end
					OP_END: begin
						inc_x_q      <= 16'sd0;
						inc_z_q      <= 16'sd0;
						count_q      <= '0;
						best_pos_q   <= '0;
						best_mag_q   <= 16'hFFFF;
						have_best_q  <= 1'b0;
						overflowed_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// answer payload, loaded with the end transfer
	always_ff @(posedge clk) begin
		if (accept && op == OP_END) begin
			found_q      <= have_best_q && !inc_zero;
			best_index_q <= (have_best_q && !inc_zero) ? best_pos_ext[3:0] : 4'd0;
			overflow_q   <= overflowed_q;
		end
	end

	`SBS_NEVER(a_start_while_busy, unit_start && ustat.busy, "turn unit started while busy")
	`SBS_ASSERT(a_done_in_wait, !ustat.done || state_q == ST_WAIT, "turn result with no candidate")
	`SBS_ASSERT(a_count_bound, count_q <= CntW'(MAX_CANDIDATES), "candidate count past capacity")
	`SBS_ASSERT(a_ovf_full, !overflowed_q || count_q == CntW'(MAX_CANDIDATES), "overflow not full")

endmodule

### test/sbs_answer_checker.sv
// Answer checker: predicts the selected branch of each query and compares it with the block.
`timescale 1ns / 1ps
module sbs_answer_checker #(
	parameter int MAX_BRANCHES = sbs_pkg::SBS_MAX_CANDIDATES,
	parameter int TURN_STEPS   = sbs_pkg::SBS_CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [15:0] heading_x,
	input  logic signed [15:0] heading_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               found,
	input  logic [3:0]         best_index,
	input  logic               overflow,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 answers_pending
);

	typedef struct packed {
		logic       found;
		logic [3:0] index;
		logic       overflow;
	} answer_t;

	// atan(2^-i) in 1/256 angle units, pi = 32768 units
	longint atan_units [0:23] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	answer_t            answer_q [$];
	bit                 uturn_ok;
	logic [15:0]        uturn_limit;
	logic signed [15:0] from_x;
	logic signed [15:0] from_z;
	int                 branches_seen;
	int                 lead_pos;
	int                 lead_turn;
	bit                 lead_valid;
	bit                 spilled;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic clear_query();
		from_x        = '0;
		from_z        = '0;
		branches_seen = 0;
		lead_pos      = 0;
		lead_turn     = 'hFFFF;
		lead_valid    = 1'b0;
		spilled       = 1'b0;
	endtask

	// |atan2(y, x)| in binary angle units by CORDIC vectoring
	function automatic int turn_units(input longint y, input longint x);
		longint ax, ay, m, cx, cy, sx, sy, acc, q;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		m  = (ax > ay) ? ax : ay;
		if (m == 0)
			return 0;
		while (m < 64'sd1073741824) begin
			m  = m <<< 1;
			ax = ax <<< 1;
			ay = ay <<< 1;
		end
		cx  = ax;
		cy  = ay;
		acc = 0;
		for (int i = 0; i < TURN_STEPS && i < 24; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (cy > 0) begin
				cx  = cx + sy;
				cy  = cy - sx;
				acc = acc + atan_units[i];
			end else begin
				cx  = cx - sy;
				cy  = cy + sx;
				acc = acc - atan_units[i];
			end
		end
		q = (acc + 128) >>> 8;
		if (q < 0)
			q = 0;
		if (q > 16384)
			q = 16384;
		return (x < 0) ? int'(32768 - q) : int'(q);
	endfunction

	task automatic track_query(input logic [1:0] item_op, input logic signed [15:0] hx,
			input logic signed [15:0] hz);
		longint  cross_v, dot;
		int      turn, pos;
		answer_t ans;
		case (item_op)
			sbs_pkg::OP_BEGIN: begin
				clear_query();
				from_x = hx;
				from_z = hz;
			end
			sbs_pkg::OP_CAND: begin
				if (branches_seen >= MAX_BRANCHES) begin
					spilled = 1'b1;
				end else begin
					pos = branches_seen;
					branches_seen++;
					// zero vectors keep their slot but never compete
					if ((from_x != 0 || from_z != 0) && (hx != 0 || hz != 0)) begin
						cross_v = longint'(from_x) * longint'(hz) - longint'(from_z) * longint'(hx);
						dot     = longint'(from_x) * longint'(hx) + longint'(from_z) * longint'(hz);
						turn    = turn_units(cross_v, dot);
						if ((uturn_ok || turn < int'(uturn_limit)) && turn < lead_turn) begin
							lead_turn  = turn;
							lead_pos   = pos;
							lead_valid = 1'b1;
						end
					end
				end
			end
			sbs_pkg::OP_END: begin
				ans.found    = lead_valid && (from_x != 0 || from_z != 0);
				ans.index    = ans.found ? 4'(lead_pos) : 4'd0;
				ans.overflow = spilled;
				answer_q.push_back(ans);
				clear_query();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_ans;
		if (!arst_n) begin
			answer_q.delete();
			fail_count      = 0;
			uturn_ok        = 1'b0;
			uturn_limit     = sbs_pkg::THR_RESET;
			clear_query();
			answers_pending <= 0;
		end else begin
			// check the answer first: one taken at this edge predates any end taken now
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("unexpected answer found=%0d index=%0d overflow=%0d",
						found, best_index, overflow));
				end else begin
					exp_ans = answer_q.pop_front();
					if (found !== exp_ans.found)
						report_mismatch($sformatf("found %0d, want %0d", found, exp_ans.found));
					if (best_index !== exp_ans.index)
						report_mismatch($sformatf("best_index %0d, want %0d",
							best_index, exp_ans.index));
					if (overflow !== exp_ans.overflow)
						report_mismatch($sformatf("overflow %0d, want %0d",
							overflow, exp_ans.overflow));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sbs_pkg::CFG_ALLOW_UTURN: uturn_ok = cfg_data[0];
					sbs_pkg::CFG_UTURN_THR:   uturn_limit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				track_query(op, heading_x, heading_z);
			answers_pending <= answer_q.size();
		end
	end

endmodule

### test/tb_straightest_branch_selector.sv
// Testbench top: drives queries and register writes into the selector and gives the verdict.
`timescale 1ns / 1ps
module tb_straightest_branch_selector;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] z;
	} heading_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = sbs_pkg::OP_BEGIN;
	logic signed [15:0] heading_x = '0;
	logic signed [15:0] heading_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic [3:0]         best_index;
	logic               overflow;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = sbs_pkg::CFG_ALLOW_UTURN;
	logic [15:0]        cfg_data = '0;

	int fail_count;
	int answers_pending;

	heading_item_t item_q [$];
	heading_item_t next_item;
	int            items_queued = 0;
	int            items_taken = 0;
	int            send_idle = 0;
	int            recv_idle = 0;
	int            cycles = 0;

	straightest_branch_selector u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.heading_x  (heading_x),
		.heading_z  (heading_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.best_index (best_index),
		.overflow   (overflow),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	sbs_answer_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.heading_x       (heading_x),
		.heading_z       (heading_z),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.best_index      (best_index),
		.overflow        (overflow),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.answers_pending (answers_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// advance the input channel: load the next item once the current one is transferred
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (item_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_item = item_q.pop_front();
				in_valid  <= 1'b1;
				op        <= next_item.op;
				heading_x <= next_item.x;
				heading_z <= next_item.z;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			items_taken <= items_taken + 1;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic queue_item(input logic [1:0] item_op, input logic signed [15:0] x,
			input logic signed [15:0] z);
		heading_item_t it;
		it.op = item_op;
		it.x  = x;
		it.z  = z;
		item_q.push_back(it);
		items_queued++;
	endtask

	task automatic wait_taken();
		do @(posedge clk); while (items_taken != items_queued);
	endtask

	task automatic wait_answers();
		do @(posedge clk); while (answers_pending != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain the block, let a trailing candidate finish, then rewrite both registers
	task automatic set_regs(input bit allow, input logic [15:0] thr);
		wait_taken();
		wait_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(sbs_pkg::CFG_ALLOW_UTURN, {15'd0, allow});
		write_reg(sbs_pkg::CFG_UTURN_THR, thr);
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'($urandom_range(8) - 4);
			4: return 16'($urandom_range(512) - 256);
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic signed [15:0] nudge(input logic signed [15:0] v);
		int t;
		t = int'(v) + int'($urandom_range(6)) - 3;
		if (t > 32767)
			t = 32767;
		if (t < -32768)
			t = -32768;
		return 16'(t);
	endfunction

	function automatic logic signed [15:0] flip(input logic signed [15:0] v);
		return (v == 16'sh8000) ? 16'sh7FFF : -v;
	endfunction

	// bias branches toward straight, reverse and square turns so the threshold gets exercised
	task automatic queue_query(input int branches);
		logic signed [15:0] ix, iz, cx, cz;
		if ($urandom_range(19) == 0) begin
			ix = '0;
			iz = '0;
		end else begin
			ix = rand_comp();
			iz = rand_comp();
		end
		queue_item(sbs_pkg::OP_BEGIN, ix, iz);
		for (int b = 0; b < branches; b++) begin
			case ($urandom_range(7))
				0: begin
					cx = nudge(ix);
					cz = nudge(iz);
				end
				1: begin
					cx = nudge(flip(ix));
					cz = nudge(flip(iz));
				end
				2: begin
					cx = flip(iz);
					cz = ix;
				end
				3: begin
					cx = '0;
					cz = '0;
				end
				default: begin
					cx = rand_comp();
					cz = rand_comp();
				end
			endcase
			queue_item(sbs_pkg::OP_CAND, cx, cz);
		end
		queue_item(sbs_pkg::OP_END, '0, '0);
	endtask

	initial begin
		int          epoch_items, branches;
		bit          allow;
		logic [15:0] thr;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// end and stray candidate with no query open
		queue_item(sbs_pkg::OP_END, '0, '0);
		queue_item(sbs_pkg::OP_CAND, 16'sd300, -16'sd20);
		queue_item(sbs_pkg::OP_END, '0, '0);
		// zero branch, straight, reverse (U-turn, excluded), square left
		queue_item(sbs_pkg::OP_BEGIN, 16'sd1000, 16'sd0);
		queue_item(sbs_pkg::OP_CAND, 16'sd0, 16'sd0);
		queue_item(sbs_pkg::OP_CAND, 16'sd1000, 16'sd0);
		queue_item(sbs_pkg::OP_CAND, -16'sd1000, 16'sd0);
		queue_item(sbs_pkg::OP_CAND, 16'sd0, 16'sd1000);
		queue_item(sbs_pkg::OP_END, '0, '0);
		// zero incoming heading
		queue_item(sbs_pkg::OP_BEGIN, 16'sd0, 16'sd0);
		queue_item(sbs_pkg::OP_CAND, 16'sd5, 16'sd5);
		queue_item(sbs_pkg::OP_END, '0, '0);
		// extreme components
		queue_item(sbs_pkg::OP_BEGIN, 16'sh8000, 16'sh8000);
		queue_item(sbs_pkg::OP_CAND, 16'sh7FFF, 16'sh8000);
		queue_item(sbs_pkg::OP_CAND, 16'sh8000, 16'sh8000);
		queue_item(sbs_pkg::OP_END, '0, '0);
		queue_item(OP_UNUSED, 16'sh7FFF, 16'sh8000);
		// equal turns either side: the earlier branch holds
		queue_item(sbs_pkg::OP_BEGIN, 16'sd1, 16'sd0);
		queue_item(sbs_pkg::OP_CAND, 16'sd1, 16'sd1);
		queue_item(sbs_pkg::OP_CAND, 16'sd1, -16'sd1);
		queue_item(sbs_pkg::OP_END, '0, '0);

		for (int epoch = 0; epoch < 12; epoch++) begin
			case (epoch / 4)
				0: begin
					send_idle = 24;
					recv_idle = 82;
				end
				1: begin
					send_idle = 82;
					recv_idle = 24;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			case (epoch)
				0: begin allow = 1'b0; thr = sbs_pkg::THR_RESET; end
				1: begin allow = 1'b0; thr = 16'd0; end
				2: begin allow = 1'b1; thr = 16'd0; end
				3: begin allow = 1'b0; thr = 16'd32768; end
				4: begin allow = 1'b0; thr = 16'hFFFF; end
				7: begin allow = 1'b0; thr = 16'd8192; end
				8: begin allow = 1'b0; thr = 16'd1; end
				9: begin allow = 1'b0; thr = 16'd32767; end
				10: begin allow = 1'b1; thr = 16'd32768; end
				default: begin
					allow = 1'($urandom_range(1));
					thr   = 16'($urandom_range(65535));
				end
			endcase
			set_regs(allow, thr);

			epoch_items = 0;
			while (epoch_items < 50) begin
				if ($urandom_range(99) < 85) begin
					branches = ($urandom_range(9) == 0) ? $urandom_range(14, 20) :
						$urandom_range(6);
					queue_query(branches);
					epoch_items += branches + 2;
				end else begin
					case ($urandom_range(3))
						0: begin
							queue_item(sbs_pkg::OP_CAND, rand_comp(), rand_comp());
							epoch_items++;
						end
						1: begin
							queue_item(sbs_pkg::OP_END, '0, '0);
							epoch_items++;
						end
						2: begin
							// abandoned query: the next begin replaces it
							queue_item(sbs_pkg::OP_BEGIN, rand_comp(), rand_comp());
							epoch_items++;
						end
						default: queue_item(OP_UNUSED, rand_comp(), rand_comp());
					endcase
				end
				// hold off now and then until the block has answered everything
				if ($urandom_range(15) == 0) begin
					wait_taken();
					wait_answers();
				end
			end
		end

		wait_taken();
		wait_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/sbs_pkg.sv
src/sbs_turn_unit.sv
src/straightest_branch_selector.sv
test/sbs_answer_checker.sv
test/tb_straightest_branch_selector.sv
